/* hdl/virtual_clock_rate_controller_assert.svh */
// assertion macros for the virtual clock rate controller
`ifndef VIRTUAL_CLOCK_RATE_CONTROLLER_ASSERT_SVH
`define VIRTUAL_CLOCK_RATE_CONTROLLER_ASSERT_SVH

// same-cycle implication, checked on every clock edge outside reset
`define VCRC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("virtual_clock_rate_controller: check failed");

// next-cycle implication
`define VCRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("virtual_clock_rate_controller: check failed");

`endif

/* hdl/vcrc_pkg.sv */
// constants and codes for the virtual clock rate controller
`timescale 1ns / 1ps
package vcrc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned S_TDATA_W  = 128;
  localparam int unsigned M_TDATA_W  = 184;

  // register reset values
  localparam logic [31:0] INIT_FREQ_RST = 32'd314000000;
  localparam logic [31:0] MIN_FREQ_RST  = 32'd1000000;
  localparam logic [31:0] MAX_FREQ_RST  = 32'd500000000;
  localparam logic [31:0] ADJ_INT_RST   = 32'd1000000000;
  localparam logic [19:0] P_GAIN_RST    = 20'd200000;
  localparam logic [19:0] I_GAIN_RST    = 20'd20000;
  localparam logic [19:0] MAX_CORR_RST  = 20'd300000;
  localparam logic [61:0] MAX_ERR_RST   = 62'd5000000000;

  localparam logic [31:0] NS_PER_SEC   = 32'd1000000000;
  localparam logic [31:0] ADJUST_SCALE = 32'd1000000;
  localparam logic [63:0] GAP_LIMIT    = 64'd4294967295;

  localparam logic [63:0] CAP_U64  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] CAP_S64  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] CAP_TERM = 64'h4000_0000_0000_0000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_FREQ = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ADJ_INT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_P_GAIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_I_GAIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CORR  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERR   = 3'd7;

  // result status codes
  localparam logic [2:0] ST_NOT_RUNNING = 3'd0;
  localparam logic [2:0] ST_BASELINE    = 3'd1;
  localparam logic [2:0] ST_IGNORED     = 3'd2;
  localparam logic [2:0] ST_REBASE      = 3'd3;
  localparam logic [2:0] ST_LOCK        = 3'd4;
  localparam logic [2:0] ST_PI          = 3'd5;

  // operations of the shared multiply-divide unit
  localparam logic [2:0] OP_VT     = 3'd0;
  localparam logic [2:0] OP_TARGET = 3'd1;
  localparam logic [2:0] OP_VEL    = 3'd2;
  localparam logic [2:0] OP_P      = 3'd3;
  localparam logic [2:0] OP_I      = 3'd4;
  localparam logic [2:0] OP_FREQ   = 3'd5;

endpackage

/* hdl/virtual_clock_rate_controller.sv */
// virtual clock rate controller: sequencer around one shared multiply-divide unit
//
//   channel  | direction | payload
//   s_axis   | in        | tdata: real_time_ns, tick_count; tuser: running
//   m_axis   | out       | tdata: frequency, virtual_time_ns, correction_ppm,
//            |           |        integrated_error; tuser: frequency_changed, status
//   cfg      | in        | register index and write data, always ready
//
// every multiply-divide runs two 32x32 partial products, a range check, one quotient
// bit per cycle, then post-processing; a sample runs one of them, three on the first
// full interval and six on later ones; the quotient steps are skipped when a
// quotient saturates
// reset clears the baseline, lock, error sum, bias and offset and loads the
// frequency with its reset value; no clearing pass is needed
// s_axis_tready is low while a sample is in work; a result waits in the output
// register and stalls the next result only, not the next input
`timescale 1ns / 1ps
`include "virtual_clock_rate_controller_assert.svh"
module virtual_clock_rate_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [62:0] real_time_ns, [125:63] tick_count, [127:126] zero
  input  logic [vcrc_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // [0] running
  input  logic [0:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] frequency, [95:32] virtual_time_ns, [116:96] correction_ppm,
  // [179:117] integrated_error, [183:180] zero
  output logic [vcrc_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // [0] frequency_changed, [3:1] status
  output logic [3:0]                          m_axis_tuser,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [vcrc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [vcrc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import vcrc_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EVAL    = 3'd1;
  localparam logic [2:0] S_MUL_LO  = 3'd2;
  localparam logic [2:0] S_MUL_HI  = 3'd3;
  localparam logic [2:0] S_DIV_CHK = 3'd4;
  localparam logic [2:0] S_DIV     = 3'd5;
  localparam logic [2:0] S_POST    = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  // configuration
  logic [31:0] min_freq_q, max_freq_q, adj_int_q;
  logic [19:0] p_gain_q, i_gain_q, max_corr_q;
  logic [61:0] max_err_q;

  // controller state
  logic [62:0]        base_rt_q, base_ticks_q, offset_q;
  logic               base_valid_q, locked_q;
  logic signed [62:0] err_sum_q;
  logic [31:0]        freq_q;
  logic signed [63:0] bias_q;

  // sequencer
  logic [2:0] state_q, op_q;
  logic       adj_q;
  logic [2:0] status_q;
  logic [5:0] cnt_q;

  // item and datapath registers
  logic [62:0]        rt_q, ticks_q;
  logic               run_q;
  logic signed [63:0] elapsed_q, executed_q, vt_q, err_q, pterm_q;
  logic [31:0]        target_q, newf_q;
  logic signed [20:0] corr_q;
  logic [95:0]        acc_q;
  logic [63:0]        rem_q, quo_q;

  // output register
  logic               out_valid_q;
  logic [31:0]        out_freq_q;
  logic signed [63:0] out_vt_q;
  logic signed [20:0] out_corr_q;
  logic signed [62:0] out_ierr_q;
  logic               out_changed_q;
  logic [2:0]         out_status_q;

  // unit operands
  logic [63:0]        op_a, op_d, op_cap;
  logic [31:0]        op_b;
  logic               op_neg;
  logic signed [63:0] diff, err_sum_ext, corr_ext;

  // combinational results
  logic signed [63:0] elapsed, executed;
  logic [64:0]        rem_sh;
  logic               q_bit;
  logic [63:0]        mag;
  logic signed [63:0] sq, err_new;
  logic signed [64:0] vt_sum, c_sum;
  logic signed [65:0] es_sum, me_ext;
  logic signed [64:0] mc_ext;
  logic signed [33:0] nf;
  logic               in_acc, out_load, changed;

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
  assign changed       = ((status_q == ST_LOCK) || (status_q == ST_PI)) && (newf_q != freq_q);

  assign elapsed  = $signed({1'b0, rt_q}) - $signed({1'b0, base_rt_q});
  assign executed = $signed({1'b0, ticks_q}) - $signed({1'b0, base_ticks_q});

  assign diff        = $signed({1'b0, ticks_q}) - $signed({1'b0, offset_q});
  assign err_sum_ext = 64'(err_sum_q);
  assign corr_ext    = 64'(corr_q);

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_d   = '0;
    op_cap = CAP_U64;
    op_neg = 1'b0;
    case (op_q)
      OP_VT: begin
        op_a   = diff[63] ? 64'(-diff) : 64'(diff);
        op_b   = NS_PER_SEC;
        op_d   = {32'b0, freq_q};
        op_cap = CAP_S64;
        op_neg = diff[63];
      end
      OP_TARGET: begin
        op_a   = 64'(executed_q);
        op_b   = NS_PER_SEC;
        op_d   = 64'(elapsed_q);
        op_cap = CAP_U64;
      end
      OP_VEL: begin
        op_a   = 64'(executed_q);
        op_b   = NS_PER_SEC;
        op_d   = {32'b0, freq_q};
        op_cap = CAP_S64;
      end
      OP_P: begin
        op_a   = err_q[63] ? 64'(-err_q) : 64'(err_q);
        op_b   = {12'b0, p_gain_q};
        op_d   = 64'(elapsed_q);
        op_cap = CAP_TERM;
        op_neg = err_q[63];
      end
      OP_I: begin
        op_a   = err_sum_ext[63] ? 64'(-err_sum_ext) : 64'(err_sum_ext);
        op_b   = {12'b0, i_gain_q};
        op_d   = {32'b0, NS_PER_SEC};
        op_cap = CAP_TERM;
        op_neg = err_sum_ext[63];
      end
      OP_FREQ: begin
        op_a   = corr_ext[63] ? 64'(-corr_ext) : 64'(corr_ext);
        op_b   = freq_q;
        op_d   = {32'b0, ADJUST_SCALE};
        op_cap = CAP_U64;
        op_neg = corr_ext[63];
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  // restoring division step, remainder one bit wider than the divisor
  assign rem_sh = {rem_q, quo_q[63]};
  assign q_bit  = (rem_sh >= {1'b0, op_d});

  // post-processing of the unit result
  assign mag     = (quo_q > op_cap) ? op_cap : quo_q;
  assign sq      = op_neg ? -$signed(mag) : $signed(mag);
  assign vt_sum  = 65'(bias_q) + 65'(sq);
  assign err_new = $signed(mag) - elapsed_q;
  assign es_sum  = 66'(err_sum_q) + 66'(err_new);
  assign me_ext  = $signed({4'b0, max_err_q});
  assign c_sum   = 65'(pterm_q) + 65'(sq);
  assign mc_ext  = $signed({45'b0, max_corr_q});
  assign nf      = $signed({2'b00, freq_q}) + $signed(sq[33:0]);

  // configuration, controller state and sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_freq_q   <= MIN_FREQ_RST;
      max_freq_q   <= MAX_FREQ_RST;
      adj_int_q    <= ADJ_INT_RST;
      p_gain_q     <= P_GAIN_RST;
      i_gain_q     <= I_GAIN_RST;
      max_corr_q   <= MAX_CORR_RST;
      max_err_q    <= MAX_ERR_RST;
      base_rt_q    <= '0;
      base_ticks_q <= '0;
      base_valid_q <= 1'b0;
      locked_q     <= 1'b0;
      err_sum_q    <= '0;
      freq_q       <= INIT_FREQ_RST;
      bias_q       <= '0;
      offset_q     <= '0;
      state_q      <= S_IDLE;
      op_q         <= OP_VT;
      adj_q        <= 1'b0;
      status_q     <= ST_NOT_RUNNING;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_MIN_FREQ: min_freq_q <= cfg_data_i[31:0];
          CFG_MAX_FREQ: max_freq_q <= cfg_data_i[31:0];
          CFG_ADJ_INT:  adj_int_q  <= cfg_data_i[31:0];
          CFG_P_GAIN:   p_gain_q   <= cfg_data_i[19:0];
          CFG_I_GAIN:   i_gain_q   <= cfg_data_i[19:0];
          CFG_MAX_CORR: max_corr_q <= cfg_data_i[19:0];
          CFG_MAX_ERR:  max_err_q  <= cfg_data_i[61:0];
          // initial frequency is not writable; reset loads the package value
          CFG_INIT_FREQ: ;
          default: ;
        endcase
      end

      if (out_valid_q && m_axis_tready && !out_load) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          adj_q   <= 1'b0;
          op_q    <= OP_VT;
          state_q <= S_MUL_LO;
          if (!run_q) begin
            status_q <= ST_NOT_RUNNING;
          end else if (!base_valid_q) begin
            base_rt_q    <= rt_q;
            base_ticks_q <= ticks_q;
            base_valid_q <= 1'b1;
            status_q     <= ST_BASELINE;
          end else if (elapsed <= 0) begin
            status_q <= ST_IGNORED;
          end else if (elapsed > $signed(GAP_LIMIT)) begin
            base_rt_q    <= rt_q;
            base_ticks_q <= ticks_q;
            status_q     <= ST_REBASE;
          end else if ((executed <= 0) || (64'(elapsed) < {32'b0, adj_int_q})) begin
            status_q <= ST_IGNORED;
          end else begin
            base_rt_q    <= rt_q;
            base_ticks_q <= ticks_q;
            status_q     <= ST_PI;
            adj_q        <= 1'b1;
          end
        end
        S_MUL_LO: state_q <= S_MUL_HI;
        S_MUL_HI: state_q <= S_DIV_CHK;
        S_DIV_CHK: begin
          cnt_q <= '0;
          if ((op_d == '0) || ({32'b0, acc_q[95:64]} >= op_d)) begin
            state_q <= S_POST;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) begin
            state_q <= S_POST;
          end
        end
        S_POST: begin
          state_q <= S_MUL_LO;
          case (op_q)
            OP_VT: begin
              if (adj_q) begin
                op_q <= OP_TARGET;
              end else begin
                state_q <= S_DONE;
              end
            end
            OP_TARGET: op_q <= OP_VEL;
            OP_VEL: begin
              if (!locked_q) begin
                err_sum_q <= '0;
                locked_q  <= 1'b1;
                status_q  <= ST_LOCK;
                state_q   <= S_DONE;
              end else begin
                if (es_sum > me_ext) begin
                  err_sum_q <= 63'(me_ext);
                end else if (es_sum < -me_ext) begin
                  err_sum_q <= 63'(-me_ext);
                end else begin
                  err_sum_q <= 63'(es_sum);
                end
                op_q <= OP_P;
              end
            end
            OP_P: op_q <= OP_I;
            OP_I: op_q <= OP_FREQ;
            OP_FREQ: state_q <= S_DONE;
            default: state_q <= S_DONE;
          endcase
        end
        S_DONE: begin
          if (out_load) begin
            if (changed) begin
              bias_q   <= vt_q;
              offset_q <= ticks_q;
              freq_q   <= newf_q;
            end
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath and output payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rt_q    <= s_axis_tdata[62:0];
      ticks_q <= s_axis_tdata[125:63];
      run_q   <= s_axis_tuser[0];
    end
    if (state_q == S_EVAL) begin
      elapsed_q  <= elapsed;
      executed_q <= executed;
    end
    case (state_q)
      S_MUL_LO: acc_q <= {32'b0, 64'(op_a[31:0]) * 64'(op_b)};
      S_MUL_HI: acc_q <= acc_q + {64'(op_a[63:32]) * 64'(op_b), 32'b0};
      S_DIV_CHK: begin
        if ((op_d == '0) || ({32'b0, acc_q[95:64]} >= op_d)) begin
          quo_q <= op_cap;
        end else begin
          rem_q <= {32'b0, acc_q[95:64]};
          quo_q <= acc_q[63:0];
        end
      end
      S_DIV: begin
        // dividend bits shift out at the top, quotient bits in at the bottom
        rem_q <= q_bit ? 64'(rem_sh - {1'b0, op_d}) : rem_sh[63:0];
        quo_q <= {quo_q[62:0], q_bit};
      end
      S_POST: begin
        case (op_q)
          OP_VT: begin
            if (vt_sum[64] != vt_sum[63]) begin
              vt_q <= vt_sum[64] ? $signed({1'b1, 63'b0}) : $signed(CAP_S64);
            end else begin
              vt_q <= vt_sum[63:0];
            end
          end
          OP_TARGET: begin
            if (mag > {32'b0, max_freq_q}) begin
              target_q <= max_freq_q;
            end else if (mag < {32'b0, min_freq_q}) begin
              target_q <= min_freq_q;
            end else begin
              target_q <= mag[31:0];
            end
          end
          OP_VEL: begin
            err_q  <= err_new;
            newf_q <= target_q;
          end
          OP_P: pterm_q <= sq;
          OP_I: begin
            if (c_sum > mc_ext) begin
              corr_q <= 21'(mc_ext);
            end else if (c_sum < -mc_ext) begin
              corr_q <= 21'(-mc_ext);
            end else begin
              corr_q <= 21'(c_sum);
            end
          end
          OP_FREQ: begin
            if (nf > $signed({2'b00, max_freq_q})) begin
              newf_q <= max_freq_q;
            end else if (nf < $signed({2'b00, min_freq_q})) begin
              newf_q <= min_freq_q;
            end else begin
              newf_q <= nf[31:0];
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (out_load) begin
      out_freq_q    <= changed ? newf_q : freq_q;
      out_vt_q      <= vt_q;
      out_corr_q    <= (status_q == ST_PI) ? corr_q : '0;
      out_ierr_q    <= err_sum_q;
      out_changed_q <= changed;
      out_status_q  <= status_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_ierr_q, out_corr_q, out_vt_q, out_freq_q};
  assign m_axis_tuser  = {out_status_q, out_changed_q};

  `VCRC_ASSERT_IMPL(a_corr_only_pi, m_axis_tvalid && (m_axis_tuser[3:1] != ST_PI), m_axis_tdata[116:96] == '0)
  `VCRC_ASSERT_IMPL(a_change_only_adjust, m_axis_tvalid && m_axis_tuser[0], (m_axis_tuser[3:1] == ST_LOCK) || (m_axis_tuser[3:1] == ST_PI))
  `VCRC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule
